[rtl/wildcard_byte_pattern_scanner_assert.svh]
// Assertion macros for the wildcard byte pattern scanner.
// Modules that include this file must provide clk_i and rst_ni.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define WBPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define WBPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/wbps_pkg.sv]
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies; compiled before every other file of the block.
package wbps_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned PAT_BYTES    = 16;
  localparam int unsigned PAT_WORD_W   = 64;
  localparam int unsigned MASK_W       = 16;
  localparam int unsigned LEN_W        = 5;
  localparam int unsigned OFFSET_OUT_W = 32;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW  = 3'd0,
    CFG_PATTERN_HIGH = 3'd1,
    CFG_WILDCARD     = 3'd2,
    CFG_LENGTH       = 3'd3
  } cfg_idx_e;

  // Register file contents as seen by the match core
  typedef struct packed {
    logic [PAT_WORD_W-1:0] pattern_high_bytes;
    logic [PAT_WORD_W-1:0] pattern_low_bytes;
    logic [MASK_W-1:0]     wildcard_mask;
    logic [LEN_W-1:0]      pattern_length;
  } cfg_t;

endpackage

[rtl/wbps_in_if.sv]
// Input byte channel of the scanner: one data byte plus end-of-region flag.
// Depends on nothing.
interface wbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/wbps_out_if.sv]
// Result channel of the scanner: found flag and match start offset.
// Depends on nothing.
interface wbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

[rtl/wbps_cfg_if.sv]
// Configuration write channel of the scanner: register index and write data.
// Depends on nothing.
interface wbps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/wbps_cfg_regs.sv]
// Configuration register file of the scanner.
// Depends on wbps_pkg and wbps_cfg_if.
module wbps_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  wbps_cfg_if.sink        cfg_i,
  output wbps_pkg::cfg_t  cfg_o
);

  wbps_pkg::cfg_t regs_q;

  // Writes are always taken
  assign cfg_i.ready = 1'b1;

  // Decode index and update the addressed register; drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else if (cfg_i.valid) begin
      case (wbps_pkg::cfg_idx_e'(cfg_i.index))
        wbps_pkg::CFG_PATTERN_LOW: begin
          regs_q.pattern_low_bytes <= cfg_i.data;
        end
        wbps_pkg::CFG_PATTERN_HIGH: begin
          regs_q.pattern_high_bytes <= cfg_i.data;
        end
        wbps_pkg::CFG_WILDCARD: begin
          regs_q.wildcard_mask <= cfg_i.data[wbps_pkg::MASK_W-1:0];
        end
        wbps_pkg::CFG_LENGTH: begin
          regs_q.pattern_length <= cfg_i.data[wbps_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = regs_q;

endmodule

[rtl/wbps_core.sv]
// Match core: input register, sliding byte window, parallel compare, result register.
// Depends on wbps_pkg, wbps_in_if, wbps_out_if and the assertion macro header.
`include "wildcard_byte_pattern_scanner_assert.svh"

module wbps_core #(
  parameter int unsigned PATTERN_MAX  = 16,
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wbps_pkg::cfg_t cfg_i,
  wbps_in_if.sink        in_i,
  wbps_out_if.source     res_o
);

  localparam int unsigned LenW = wbps_pkg::LEN_W;
  localparam int unsigned OutW = wbps_pkg::OFFSET_OUT_W;
  localparam int unsigned ByteW = wbps_pkg::BYTE_W;
  localparam logic [LenW-1:0] MaxLen = LenW'(PATTERN_MAX);
  localparam logic [OFFSET_WIDTH-1:0] SeenMax = {OFFSET_WIDTH{1'b1}};

  // Input register
  logic             in_vld_q;
  logic [ByteW-1:0] in_data_q;
  logic             in_last_q;

  // Region state
  logic [ByteW-1:0]        win_q [PATTERN_MAX];
  logic [ByteW-1:0]        win_d [PATTERN_MAX];
  logic [OFFSET_WIDTH-1:0] seen_q;
  logic [OFFSET_WIDTH-1:0] seen_d;
  logic                    done_q;

  // Result register
  logic            out_vld_q;
  logic            found_q;
  logic [OutW-1:0] offset_q;

  // Compare path
  logic                             adv;
  logic                             in_rdy;
  logic [LenW-1:0]                  len_c;
  logic [OFFSET_WIDTH-1:0]          len_ext;
  logic [wbps_pkg::PAT_BYTES*ByteW-1:0] pat;
  logic                             sat;
  logic                             all_eq;
  logic                             hit;
  logic                             emit;
  logic [OFFSET_WIDTH-1:0]          offset_full;

  // Advance the registered word when the result slot is free or draining
  assign adv      = in_vld_q && (!out_vld_q || res_o.ready);
  assign in_rdy   = !in_vld_q || adv;
  assign in_i.ready = in_rdy;

  // Clamp length and gather the pattern bytes
  assign len_c   = (cfg_i.pattern_length > MaxLen) ? MaxLen : cfg_i.pattern_length;
  assign len_ext = OFFSET_WIDTH'(len_c);
  assign pat     = {cfg_i.pattern_high_bytes, cfg_i.pattern_low_bytes};

  // Shift the new byte into the window, newest at entry 0
  always_comb begin
    win_d[0] = in_data_q;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  // Saturating byte count
  assign sat    = (seen_q == SeenMax);
  assign seen_d = sat ? seen_q : seen_q + OFFSET_WIDTH'(1);

  // Compare pattern byte i with window entry len-1-i, skipping wildcards
  always_comb begin
    logic [LenW-1:0]  j;
    logic [ByteW-1:0] sel;
    all_eq = (len_c != '0) && (seen_d >= len_ext);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      j   = len_c - LenW'(1) - LenW'(i);
      sel = '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        if (LenW'(k) == j) begin
          sel = win_d[k];
        end
      end
      if ((LenW'(i) < len_c) && !cfg_i.wildcard_mask[i] &&
          (sel != pat[ByteW*i +: ByteW])) begin
        all_eq = 1'b0;
      end
    end
  end

  assign hit         = !done_q && all_eq;
  assign emit        = hit || (in_last_q && !done_q);
  assign offset_full = sat ? SeenMax : seen_d - len_ext;

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_rdy) begin
      in_vld_q <= in_i.valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_rdy && in_i.valid) begin
      in_data_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  // Window, count and done flag; clear count at region end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        win_q[k] <= '0;
      end
      seen_q <= '0;
      done_q <= 1'b0;
    end else if (adv) begin
      win_q <= win_d;
      if (in_last_q) begin
        seen_q <= '0;
        done_q <= 1'b0;
      end else begin
        seen_q <= seen_d;
        done_q <= done_q || hit;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= emit;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      found_q  <= hit;
      offset_q <= hit ? OutW'(offset_full) : '0;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.found        = found_q;
  assign res_o.match_offset = offset_q;

  // Checks
  `WBPS_ASSERT_IMP(a_miss_zero_offset, out_vld_q && !found_q, offset_q == '0,
                   "not-found result carries a nonzero offset")
  `WBPS_ASSERT_NXT(a_done_silent, adv && done_q, !out_vld_q,
                   "result produced after a match was already reported")
  `WBPS_ASSERT_NXT(a_region_clear, adv && in_last_q, seen_q == '0 && !done_q,
                   "region state not cleared after the last byte")
  `WBPS_ASSERT_IMP(a_ready_when_free, !out_vld_q, in_rdy,
                   "input stalled while the result slot is empty")

endmodule

[rtl/wildcard_byte_pattern_scanner.sv]
// Wildcard byte pattern scanner, top level.
// A taken byte enters the input register; its result is registered once the result slot is free.
// One byte per cycle unless the result side stalls; the compare checks all positions in parallel.
// A region yields one result: found at the byte ending the first match, else not found at its last byte.
// Reset (rst_ni low, asynchronous) clears configuration, window, byte count and all valid flags.
// Depends on wbps_pkg, the channel interfaces, wbps_cfg_regs and wbps_core.
module wildcard_byte_pattern_scanner #(
  parameter int unsigned PATTERN_MAX  = 16,
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wbps_cfg_if.sink   cfg_i,
  wbps_in_if.sink    in_i,
  wbps_out_if.source res_o
);

  wbps_pkg::cfg_t cfg;

  // Register file
  wbps_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Window and compare
  wbps_core #(
    .PATTERN_MAX  (PATTERN_MAX),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .res_o  (res_o)
  );

endmodule

[bench/wbps_match_checker.sv]
`timescale 1ns / 1ps
// Checker for the wildcard byte pattern scanner: tracks configuration writes,
// predicts the found/offset word of each region and compares it with the result channel.
// Depends on wbps_pkg and the cfg, input and result channel interfaces.
module wbps_match_checker
  import wbps_pkg::*;
#(
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  wbps_cfg_if  cfg_w,
  wbps_in_if   in_w,
  wbps_out_if  res_w,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic                    found;
    logic [OFFSET_OUT_W-1:0] match_offset;
  } region_verdict_t;

  localparam longint unsigned SEEN_MAX = (64'd1 << OFFSET_WIDTH) - 64'd1;

  // Shadow copy of the configuration registers
  logic [PAT_WORD_W-1:0] pat_lo;
  logic [PAT_WORD_W-1:0] pat_hi;
  logic [MASK_W-1:0]     wild_mask;
  logic [LEN_W-1:0]      scan_len;

  // Region scan state
  logic [BYTE_W-1:0] window [PAT_BYTES];
  longint unsigned   seen;
  logic              done;

  region_verdict_t verdicts_q[$];
  int              mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [BYTE_W-1:0] pattern_byte(input int unsigned i);
    return (i < 8) ? pat_lo[i*8 +: 8] : pat_hi[(i-8)*8 +: 8];
  endfunction

  task automatic clear_region();
    foreach (window[i]) window[i] = '0;
    seen = 0;
    done = 1'b0;
  endtask

  task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_PATTERN_LOW:  pat_lo    = value;
      CFG_PATTERN_HIGH: pat_hi    = value;
      CFG_WILDCARD:     wild_mask = value[MASK_W-1:0];
      CFG_LENGTH:       scan_len  = value[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // Shift one byte into the window and queue the region verdict it causes, if any
  task automatic advance_scan(input logic [BYTE_W-1:0] data, input logic is_last);
    int unsigned     len;
    logic            was_saturated;
    logic            hit;
    region_verdict_t verdict;
    len = (scan_len > PAT_BYTES) ? PAT_BYTES : scan_len;
    for (int i = PAT_BYTES - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = data;
    was_saturated = (seen >= SEEN_MAX);
    if (!was_saturated) seen++;
    hit = (len != 0) && (seen >= len);
    for (int i = 0; i < len; i++) begin
      if (!wild_mask[i] && window[len-1-i] != pattern_byte(i)) hit = 1'b0;
    end
    if (!done && hit) begin
      verdict.found        = 1'b1;
      verdict.match_offset = OFFSET_OUT_W'(was_saturated ? SEEN_MAX : seen - len);
      verdicts_q = {verdicts_q, verdict};
      done = 1'b1;
    end else if (is_last && !done) begin
      verdict = '0;
      verdicts_q = {verdicts_q, verdict};
    end
    if (is_last) clear_region();
  endtask

  task automatic check_result(input logic found, input logic [OFFSET_OUT_W-1:0] offset);
    region_verdict_t want;
    if (verdicts_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: found=%0b offset=%0d",
                                found, offset));
    end else begin
      want = verdicts_q.pop_front();
      if (found !== want.found)
        report_mismatch($sformatf("found=%0b, predicted %0b", found, want.found));
      if (offset !== want.match_offset)
        report_mismatch($sformatf("match_offset=%0d, predicted %0d (found=%0b)",
                                  offset, want.match_offset, want.found));
    end
  endtask

  // Watch all three channels; words move at edges where valid and ready are both high
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo    = '0;
      pat_hi    = '0;
      wild_mask = '0;
      scan_len  = '0;
      clear_region();
      verdicts_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_w.valid && cfg_w.ready) apply_reg_write(cfg_w.index, cfg_w.data);
      if (in_w.valid && in_w.ready) advance_scan(in_w.data_byte, in_w.last_byte);
      if (res_w.valid && res_w.ready) check_result(res_w.found, res_w.match_offset);
      pending_o <= verdicts_q.size();
    end
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Top of the wildcard byte pattern scanner bench: clock, reset, configuration phases and
// byte regions with random idling; the verdict comes from wbps_match_checker's failure count.
// Depends on wbps_pkg, the channel interfaces, the scanner and wbps_match_checker.
module tb;
  import wbps_pkg::*;

  localparam int unsigned OFFSET_WIDTH  = 32;
  localparam int unsigned IDLE_PCT      = 7;
  localparam int unsigned LATENCY_WAIT  = 6;
  localparam int unsigned RANDOM_ITEMS  = 550;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_BASE = CFG_LENGTH;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  wbps_cfg_if cfg_w ();
  wbps_in_if  in_w ();
  wbps_out_if res_w ();

  int fails;
  int pending;

  wildcard_byte_pattern_scanner #(
    .PATTERN_MAX  (PAT_BYTES),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_w),
    .in_i   (in_w),
    .res_o  (res_w)
  );

  wbps_match_checker #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_w        (cfg_w),
    .in_w         (in_w),
    .res_w        (res_w),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  // Pattern currently loaded into the block
  logic [BYTE_W-1:0] pat [PAT_BYTES];
  logic [MASK_W-1:0] wild;
  logic [LEN_W-1:0]  plen;
  logic              calm = 1'b0;

  // Stall the result side at random unless in a calm stretch
  always @(posedge clk_i) begin
    res_w.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Abort a hung run
  int unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("wildcard_byte_pattern_scanner test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_w.valid <= 1'b1;
    cfg_w.index <= idx;
    cfg_w.data  <= value;
    do @(posedge clk_i); while (!cfg_w.ready);
  endtask

  // Write all four registers from pat/wild/plen; with poke_unused a stray index goes last so aliasing shows
  task automatic load_config(input logic poke_unused);
    logic [PAT_WORD_W-1:0] lo;
    logic [PAT_WORD_W-1:0] hi;
    for (int i = 0; i < 8; i++) begin
      lo[i*8 +: 8] = pat[i];
      hi[i*8 +: 8] = pat[i+8];
    end
    write_reg(CFG_PATTERN_LOW, lo);
    write_reg(CFG_PATTERN_HIGH, hi);
    write_reg(CFG_WILDCARD, CFG_DATA_W'(wild));
    write_reg(CFG_LENGTH, CFG_DATA_W'(plen));
    if (poke_unused)
      write_reg(CFG_UNUSED_BASE + CFG_IDX_W'($urandom_range(1, 4)),
                {$urandom, $urandom});
    cfg_w.valid <= 1'b0;
  endtask

  // Offer one byte, idling first at random
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_w.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_w.valid     <= 1'b1;
    in_w.data_byte <= b;
    in_w.last_byte <= is_last;
    do @(posedge clk_i); while (!in_w.ready);
  endtask

  task automatic send_region(input logic [BYTE_W-1:0] region_bytes[$]);
    foreach (region_bytes[i]) send_byte(region_bytes[i], i == region_bytes.size() - 1);
  endtask

  // Drop valid, wait for every predicted word, then let the pipeline drain
  task automatic wait_idle();
    in_w.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (LATENCY_WAIT) @(posedge clk_i);
  endtask

  initial begin
    int unsigned       random_items;
    int unsigned       phase_items;
    int unsigned       phase_goal;
    int unsigned       phase;
    int unsigned       kind;
    int unsigned       pick;
    int unsigned       eff_len;
    int unsigned       embed_len;
    int unsigned       corrupt;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] region_q[$];

    cfg_w.valid     = 1'b0;
    cfg_w.index     = CFG_PATTERN_LOW;
    cfg_w.data      = '0;
    in_w.valid      = 1'b0;
    in_w.data_byte  = '0;
    in_w.last_byte  = 1'b0;
    random_items    = 0;
    phase           = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset config has zero length: no region may match
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b1);

    // Three-byte exact pattern
    wait_idle();
    foreach (pat[i]) pat[i] = '0;
    pat[0] = 8'hAA;
    pat[1] = 8'hBB;
    pat[2] = 8'hCC;
    wild = '0;
    plen = 5'd3;
    load_config(1'b1);
    // match mid-region, trailing byte gives nothing more
    send_region('{8'h11, 8'hAA, 8'hBB, 8'hCC, 8'h22});
    // match ending on the last byte
    send_region('{8'hAA, 8'hBB, 8'hCC});
    // pattern split across two regions must not match
    send_region('{8'hAA, 8'hBB});
    send_region('{8'hCC});

    // Wildcard in the first position
    wait_idle();
    pat[1] = 8'hFF;
    wild = 16'h0001;
    plen = 5'd2;
    load_config(1'b0);
    send_region('{8'h00, 8'hFF});
    send_region('{8'h5A, 8'h00, 8'hFF});

    // Random phases: mostly embedded patterns, some broken or cut short, some noise
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      calm = (phase == 3 || phase == 4);
      case (phase)
        0: begin
          foreach (pat[i]) pat[i] = 8'hFF;
          wild = '0;
          plen = LEN_W'(PAT_BYTES);
        end
        1: begin
          foreach (pat[i]) pat[i] = BYTE_W'($urandom);
          wild = '1;
          plen = '1;
        end
        2: begin
          foreach (pat[i]) pat[i] = 8'h00;
          wild = '0;
          plen = LEN_W'(PAT_BYTES);
        end
        default: begin
          foreach (pat[i]) pat[i] = BYTE_W'($urandom);
          pick = $urandom_range(0, 9);
          case (pick)
            0:       plen = '0;
            1:       plen = 5'd1;
            2:       plen = LEN_W'(PAT_BYTES);
            3:       plen = LEN_W'($urandom_range(PAT_BYTES + 1, 31));
            default: plen = LEN_W'($urandom_range(2, 8));
          endcase
          pick = $urandom_range(0, 3);
          case (pick)
            0:       wild = '0;
            1:       wild = '1;
            2:       wild = MASK_W'($urandom & $urandom);
            default: wild = MASK_W'($urandom);
          endcase
        end
      endcase
      load_config(phase[0]);
      eff_len = (plen > PAT_BYTES) ? PAT_BYTES : plen;

      phase_items = 0;
      phase_goal  = $urandom_range(30, 60);
      while (phase_items < phase_goal) begin
        region_q.delete();
        kind = $urandom_range(0, 99);
        repeat ($urandom_range(0, 6)) region_q = {region_q, BYTE_W'($urandom)};
        if (kind < 70 && eff_len != 0) begin
          // embed the pattern, twice for some kinds; some regions end inside it, others get a corrupt byte
          embed_len = (kind >= 45 && kind < 55) ? eff_len - 1 : eff_len;
          corrupt   = $urandom_range(0, eff_len - 1);
          repeat ((kind < 20) ? 2 : 1) begin
            for (int i = 0; i < embed_len; i++) begin
              b = wild[i] ? BYTE_W'($urandom) : pat[i];
              if (kind >= 55 && i == corrupt) b = b ^ BYTE_W'($urandom_range(1, 255));
              region_q = {region_q, b};
            end
            if (kind < 20)
              repeat ($urandom_range(0, 3)) region_q = {region_q, BYTE_W'($urandom)};
          end
          if (!(kind >= 45 && kind < 55))
            repeat ($urandom_range(0, 5)) region_q = {region_q, BYTE_W'($urandom)};
        end else begin
          repeat ($urandom_range(1, 20)) region_q = {region_q, BYTE_W'($urandom)};
        end
        if (region_q.size() == 0) region_q = {region_q, BYTE_W'($urandom)};
        send_region(region_q);
        phase_items  += region_q.size();
        random_items += region_q.size();
      end
      phase++;
    end

    calm = 1'b0;
    wait_idle();
    if (fails == 0) begin
      $display("wildcard_byte_pattern_scanner test passed");
    end else begin
      $display("wildcard_byte_pattern_scanner test failed");
    end
    $finish;
  end

endmodule
